@@ hw/rtl/bresenham_line_stepper_core_defines.svh @@
// assertion macros used by the checker file bls_checker.sv
`ifndef BRESENHAM_LINE_STEPPER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_CORE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, gated by a disable expression
`define ASSERT_HOLDS(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, clocked on i_clk, gated by a disable expression
`define ASSERT_NEXT(lbl, dis, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Types and constants shared by the line stepper modules.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int FIELD_COORD_W  = 6;
    localparam int COLOUR_W       = 8;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic [FIELD_COORD_W-1:0] x_start;
        logic [FIELD_COORD_W-1:0] y_start;
        logic [FIELD_COORD_W-1:0] x_end;
        logic [FIELD_COORD_W-1:0] y_end;
        logic [COLOUR_W-1:0]      red_in;
        logic [COLOUR_W-1:0]      green_in;
        logic [COLOUR_W-1:0]      blue_in;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_COORD_W-1:0] pixel_x;
        logic [FIELD_COORD_W-1:0] pixel_y;
        logic [COLOUR_W-1:0]      red_out;
        logic [COLOUR_W-1:0]      green_out;
        logic [COLOUR_W-1:0]      blue_out;
        logic                     last_pixel;
    } t_out_item;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } t_colour;

    localparam int COLOUR_BITS = $bits(t_colour);

    typedef enum logic {
        BackIdle,
        BackRun
    } t_back_state;

endpackage

@@ hw/rtl/bls_front.sv @@
// ----------------------------------------------------------------------------
// bls_front
// Accepts line items and classifies them: deltas, directions, major axis.
// ----------------------------------------------------------------------------
module bls_front
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3 + COLOUR_BITS
) (
    input  t_in_item           i_item,
    input  logic               push,
    output logic               full,
    input  logic               i_q_full,
    output logic               o_q_wr_en,
    output logic [ENTRY_W-1:0] o_q_wr_data
);

    logic [COORD_BITS-1:0] w_xs, w_ys, w_xe, w_ye;
    logic [COORD_BITS-1:0] w_adx, w_ady, w_amaj, w_amin;
    logic                  w_sxn, w_syn, w_xmaj;
    t_colour               w_colour;

    always_comb begin
        // coordinate bits above the tile size are dropped
        w_xs = i_item.x_start[COORD_BITS-1:0];
        w_ys = i_item.y_start[COORD_BITS-1:0];
        w_xe = i_item.x_end[COORD_BITS-1:0];
        w_ye = i_item.y_end[COORD_BITS-1:0];
        w_sxn = (w_xe < w_xs);
        w_syn = (w_ye < w_ys);
        w_adx = w_sxn ? (w_xs - w_xe) : (w_xe - w_xs);
        w_ady = w_syn ? (w_ys - w_ye) : (w_ye - w_ys);
        // diagonal and zero-length lines go y-major
        w_xmaj = (w_adx > w_ady);
        w_amaj = w_xmaj ? w_adx : w_ady;
        w_amin = w_xmaj ? w_ady : w_adx;
        w_colour.red   = i_item.red_in;
        w_colour.green = i_item.green_in;
        w_colour.blue  = i_item.blue_in;
    end

    assign full        = i_q_full;
    assign o_q_wr_en   = push && !i_q_full;
    assign o_q_wr_data = {w_colour, w_xmaj, w_syn, w_sxn, w_amin, w_amaj, w_ys, w_xs};

endmodule

@@ hw/rtl/bls_queue.sv @@
// ----------------------------------------------------------------------------
// bls_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bls_queue
    import bls_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ hw/rtl/bls_back.sv @@
// ----------------------------------------------------------------------------
// bls_back
// Steps one queued line a pixel per cycle into the result register while it is free or popped.
// ----------------------------------------------------------------------------
module bls_back
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ENTRY_W    = 4 * COORD_BITS + 3 + COLOUR_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [ENTRY_W-1:0] i_q_rd_data,
    output logic               o_q_rd_en,
    output t_out_item          o_result,
    output logic               empty,
    input  logic               pop
);

    // error term range is about +-2^(COORD_BITS+1), sign in the top bit
    localparam int ERR_W = COORD_BITS + 3;

    t_back_state           r_state, n_state;
    logic [COORD_BITS-1:0] r_px, r_py, r_cnt, n_px, n_py, n_cnt;
    logic [ERR_W-1:0]      r_err, r_inc_step, r_inc_hold;
    logic [ERR_W-1:0]      n_err, n_inc_step, n_inc_hold;
    logic                  r_sxn, r_syn, r_xmaj, n_sxn, n_syn, n_xmaj;
    t_colour               r_colour, n_colour;
    logic                  r_ov, n_ov;
    t_out_item             r_out, n_out;

    logic [COORD_BITS-1:0] w_xs, w_ys, w_amaj, w_amin;
    logic                  w_sxn, w_syn, w_xmaj;
    t_colour               w_colour;
    logic [ERR_W-1:0]      w_min2;
    logic                  w_out_free, w_minor, w_xstep, w_ystep;

    assign {w_colour, w_xmaj, w_syn, w_sxn, w_amin, w_amaj, w_ys, w_xs} = i_q_rd_data;
    assign w_min2     = ERR_W'({w_amin, 1'b0});
    assign w_out_free = !r_ov || pop;
    assign w_minor    = !r_err[ERR_W-1];
    assign w_xstep    = r_xmaj || w_minor;
    assign w_ystep    = !r_xmaj || w_minor;

    always_comb begin
        n_state    = r_state;
        n_px       = r_px;
        n_py       = r_py;
        n_cnt      = r_cnt;
        n_err      = r_err;
        n_inc_step = r_inc_step;
        n_inc_hold = r_inc_hold;
        n_sxn      = r_sxn;
        n_syn      = r_syn;
        n_xmaj     = r_xmaj;
        n_colour   = r_colour;
        n_ov       = r_ov && !pop;
        n_out      = r_out;
        o_q_rd_en  = 1'b0;
        unique case (r_state)
            BackIdle: begin
                if (!i_q_empty) begin
                    o_q_rd_en  = 1'b1;
                    n_px       = w_xs;
                    n_py       = w_ys;
                    n_cnt      = w_amaj;
                    n_err      = w_min2 - ERR_W'(w_amaj);
                    n_inc_hold = w_min2;
                    n_inc_step = w_min2 - ERR_W'({w_amaj, 1'b0});
                    n_sxn      = w_sxn;
                    n_syn      = w_syn;
                    n_xmaj     = w_xmaj;
                    n_colour   = w_colour;
                    n_state    = BackRun;
                end
            end
            BackRun: begin
                if (w_out_free) begin
                    n_ov             = 1'b1;
                    n_out.pixel_x    = FIELD_COORD_W'(r_px);
                    n_out.pixel_y    = FIELD_COORD_W'(r_py);
                    n_out.red_out    = r_colour.red;
                    n_out.green_out  = r_colour.green;
                    n_out.blue_out   = r_colour.blue;
                    n_out.last_pixel = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = BackIdle;
                    end else begin
                        // major axis always moves, minor axis when error is non-negative
                        n_err = w_minor ? (r_err + r_inc_step) : (r_err + r_inc_hold);
                        if (w_xstep) begin
                            n_px = r_sxn ? (r_px - 1'b1) : (r_px + 1'b1);
                        end
                        if (w_ystep) begin
                            n_py = r_syn ? (r_py - 1'b1) : (r_py + 1'b1);
                        end
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: n_state = BackIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BackIdle;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px       <= n_px;
        r_py       <= n_py;
        r_cnt      <= n_cnt;
        r_err      <= n_err;
        r_inc_step <= n_inc_step;
        r_inc_hold <= n_inc_hold;
        r_sxn      <= n_sxn;
        r_syn      <= n_syn;
        r_xmaj     <= n_xmaj;
        r_colour   <= n_colour;
        r_out      <= n_out;
    end

    assign o_result = r_out;
    assign empty    = !r_ov;

endmodule

@@ hw/rtl/bresenham_line_stepper_core.sv @@
// A line item (two endpoints in a 2^COORD_BITS square tile plus an RGB colour)
// is pushed into a two-entry queue; each line then yields max(|dx|,|dy|)+1
// pixel results, one per cycle while results are popped, with last_pixel set
// on the final one. In the stepper a line is first loaded from the queue and
// then stepped one pixel at a time. Up to two further lines wait in the
// queue, so push stays open while a line is being drawn until both queue
// entries are taken.
// ----------------------------------------------------------------------------
// bresenham_line_stepper_core
// Integer line stepper for all octants with queue-style ports on both sides.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_core
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      push,
    output logic      full,
    output t_out_item o_result,
    output logic      empty,
    input  logic      pop
);

    localparam int ENTRY_W = 4 * COORD_BITS + 3 + COLOUR_BITS;

    logic               w_q_wr_en, w_q_rd_en, w_q_full, w_q_empty;
    logic [ENTRY_W-1:0] w_q_wr_data, w_q_rd_data;

    bls_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_item      (i_item),
        .push        (push),
        .full        (full),
        .i_q_full    (w_q_full),
        .o_q_wr_en   (w_q_wr_en),
        .o_q_wr_data (w_q_wr_data)
    );

    bls_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_q_wr_en),
        .i_wr_data (w_q_wr_data),
        .i_rd_en   (w_q_rd_en),
        .o_rd_data (w_q_rd_data),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    bls_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_rd_data (w_q_rd_data),
        .o_q_rd_en   (w_q_rd_en),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

@@ hw/rtl/bls_checker.sv @@
// ----------------------------------------------------------------------------
// bls_checker
// Port-level checks of the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
`include "bresenham_line_stepper_core_defines.svh"

module bls_checker
    import bls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input t_out_item o_result,
    input logic      empty,
    input logic      pop
);

    logic                  w_last_pop;
    logic                  w_in_tile;
    logic [3*COLOUR_W-1:0] w_colour;

    assign w_last_pop = pop && !empty && !o_result.last_pixel;
    assign w_in_tile  = ((o_result.pixel_x >> COORD_BITS) == '0)
                     && ((o_result.pixel_y >> COORD_BITS) == '0);
    assign w_colour   = {o_result.red_out, o_result.green_out, o_result.blue_out};

    // queue and result register come up empty
    `ASSERT_NEXT(a_reset_empty, 1'b0, !i_rst_n, empty && !full)

    // a waiting result holds until transfer
    `ASSERT_NEXT(a_result_hold, !i_rst_n, !empty && !pop, !empty && $stable(o_result))

    // every pixel lies inside the tile
    `ASSERT_HOLDS(a_in_tile, !i_rst_n, !empty, w_in_tile)

    // pixels of one line share its colour
    `ASSERT_HOLDS(a_same_colour, !i_rst_n, $past(w_last_pop) && !empty, w_colour == $past(w_colour))

endmodule

bind bresenham_line_stepper_core bls_checker #(
    .COORD_BITS (COORD_BITS)
) u_bls_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .o_result (o_result),
    .empty    (empty),
    .pop      (pop)
);

@@ tb/line_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches the line and pixel channels of the line stepper. Every line
// transfer is expanded into the pixels it should produce, and every pixel
// transfer is compared field by field with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module line_pixel_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bls_pkg::t_in_item   i_item,
    input  logic                i_push,
    input  logic                i_full,
    input  bls_pkg::t_out_item  i_result,
    input  logic                i_empty,
    input  logic                i_pop,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int COORD_MASK  = (1 << COORD_BITS_DEF) - 1;
    localparam int MAX_REPORTS = 10;

    t_out_item owed_pixels[$];
    int        fail_count = 0;

    // integer stepping over all octants, minor axis moves when err >= 0
    function automatic void plot_line(t_in_item line);
        int        xs, ys, xe, ye;
        int        dx, dy, sx, sy;
        int        px, py, steps, err, err_step, err_hold;
        bit        x_major;
        t_out_item pix;
        xs = int'(line.x_start) & COORD_MASK;
        ys = int'(line.y_start) & COORD_MASK;
        xe = int'(line.x_end) & COORD_MASK;
        ye = int'(line.y_end) & COORD_MASK;
        dx = (xe >= xs) ? xe - xs : xs - xe;
        dy = (ye >= ys) ? ye - ys : ys - ye;
        sx = (xe < xs) ? -1 : 1;
        sy = (ye < ys) ? -1 : 1;
        px = xs;
        py = ys;
        // diagonal and zero-length lines count as y-major
        x_major = (dx > dy);
        if (x_major) begin
            steps    = dx;
            err      = 2 * dy - dx;
            err_step = 2 * (dy - dx);
            err_hold = 2 * dy;
        end else begin
            steps    = dy;
            err      = 2 * dx - dy;
            err_step = 2 * (dx - dy);
            err_hold = 2 * dx;
        end
        for (int n = 0; n <= steps; n++) begin
            if (n > 0) begin
                if (err >= 0) begin
                    if (x_major) begin
                        py += sy;
                    end else begin
                        px += sx;
                    end
                    err += err_step;
                end else begin
                    err += err_hold;
                end
                if (x_major) begin
                    px += sx;
                end else begin
                    py += sy;
                end
            end
            pix.pixel_x    = px[FIELD_COORD_W-1:0];
            pix.pixel_y    = py[FIELD_COORD_W-1:0];
            pix.red_out    = line.red_in;
            pix.green_out  = line.green_in;
            pix.blue_out   = line.blue_in;
            pix.last_pixel = (n == steps);
            owed_pixels.push_back(pix);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_push && !i_full) begin
                plot_line(i_item);
            end
            if (i_pop && !i_empty) begin
                if (owed_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                                 i_result.pixel_x, i_result.pixel_y, i_result.last_pixel);
                    end
                end else begin
                    want = owed_pixels.pop_front();
                    if (i_result.pixel_x !== want.pixel_x
                            || i_result.pixel_y !== want.pixel_y
                            || i_result.red_out !== want.red_out
                            || i_result.green_out !== want.green_out
                            || i_result.blue_out !== want.blue_out
                            || i_result.last_pixel !== want.last_pixel) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: expected x=%0d y=%0d rgb=%h_%h_%h last=%0b",
                                     $realtime, want.pixel_x, want.pixel_y, want.red_out,
                                     want.green_out, want.blue_out, want.last_pixel);
                            $display("%0t: got      x=%0d y=%0d rgb=%h_%h_%h last=%0b",
                                     $realtime, i_result.pixel_x, i_result.pixel_y,
                                     i_result.red_out, i_result.green_out, i_result.blue_out,
                                     i_result.last_pixel);
                        end
                    end
                end
            end
        end
        o_pending    <= owed_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Line stepper testbench: directed lines through every octant and the tile
// edges, then random lines with random gaps on both channels, then random lines
// at full rate. Checking is done by line_pixel_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 80;

    logic      i_clk;
    logic      i_rst_n;
    t_in_item  line_in;
    logic      push;
    logic      full;
    t_out_item pixel_out;
    logic      empty;
    logic      pop;

    int fail_count;
    int pending_pixels;
    int cycle_count = 0;
    int push_gap_pct = 0;
    int pop_stall_pct = 0;
    int pop_stall_left = 0;
    bit push_held = 0;

    bresenham_line_stepper_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (line_in),
        .push     (push),
        .full     (full),
        .o_result (pixel_out),
        .empty    (empty),
        .pop      (pop)
    );

    line_pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (line_in),
        .i_push       (push),
        .i_full       (full),
        .i_result     (pixel_out),
        .i_empty      (empty),
        .i_pop        (pop),
        .o_fail_count (fail_count),
        .o_pending    (pending_pixels)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item make_line(int xs, int ys, int xe, int ye,
                                           int red, int green, int blue);
        t_in_item line;
        line.x_start  = xs[FIELD_COORD_W-1:0];
        line.y_start  = ys[FIELD_COORD_W-1:0];
        line.x_end    = xe[FIELD_COORD_W-1:0];
        line.y_end    = ye[FIELD_COORD_W-1:0];
        line.red_in   = red[COLOUR_W-1:0];
        line.green_in = green[COLOUR_W-1:0];
        line.blue_in  = blue[COLOUR_W-1:0];
        return line;
    endfunction

    function automatic t_in_item random_line();
        int xs, ys, xe, ye, kind;
        xs   = $urandom_range(63);
        ys   = $urandom_range(63);
        xe   = $urandom_range(63);
        ye   = $urandom_range(63);
        kind = $urandom_range(99);
        if (kind >= 60 && kind < 85) begin
            // short line, may wrap across the tile edge
            xe = xs + $urandom_range(8) - 4;
            ye = ys + $urandom_range(8) - 4;
        end else if (kind >= 85 && kind < 90) begin
            ye = ys;
        end else if (kind >= 90 && kind < 95) begin
            xe = xs;
        end else if (kind >= 95) begin
            ye = ys + (xe - xs);
        end
        return make_line(xs, ys, xe, ye, $urandom_range(255), $urandom_range(255),
                         $urandom_range(255));
    endfunction

    task automatic send_line(input t_in_item line);
        int gap;
        line_in <= line;
        push    <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        // transfer done at this edge
        gap = ($urandom_range(99) < push_gap_pct) ? gap_len() : 0;
        push_held = (gap == 0);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        if (push_held) begin
            push <= 1'b0;
            push_held = 0;
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_pixels != 0);
    endtask

    // pixel side
    initial begin
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (pop_stall_left > 0) begin
                pop <= 1'b0;
                pop_stall_left--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(99) < pop_stall_pct) begin
                    pop_stall_left = gap_len();
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        line_in = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines, back to back
        send_line(make_line(0, 0, 0, 0, 8'hff, 8'h00, 8'hff));
        send_line(make_line(63, 63, 63, 63, 8'h00, 8'hff, 8'h00));
        send_line(make_line(0, 0, 63, 0, 8'ha5, 8'h5a, 8'ha5));
        send_line(make_line(63, 63, 0, 63, 8'h5a, 8'ha5, 8'h5a));
        send_line(make_line(0, 0, 0, 63, 8'h01, 8'h80, 8'h7f));
        send_line(make_line(63, 63, 63, 0, 8'hfe, 8'h7f, 8'h80));
        send_line(make_line(0, 0, 63, 63, 8'hff, 8'hff, 8'hff));
        send_line(make_line(63, 0, 0, 63, 8'h00, 8'h00, 8'h00));
        send_line(make_line(63, 63, 0, 0, 8'h12, 8'h34, 8'h56));
        send_line(make_line(0, 63, 63, 0, 8'h65, 8'h43, 8'h21));
        // one line per octant
        send_line(make_line(10, 10, 30, 15, 8'h11, 8'h22, 8'h33));
        send_line(make_line(10, 10, 15, 30, 8'h44, 8'h55, 8'h66));
        send_line(make_line(30, 10, 25, 30, 8'h77, 8'h88, 8'h99));
        send_line(make_line(30, 10, 10, 15, 8'haa, 8'hbb, 8'hcc));
        send_line(make_line(30, 15, 10, 10, 8'hdd, 8'hee, 8'hf0));
        send_line(make_line(15, 30, 10, 10, 8'h0f, 8'h1e, 8'h2d));
        send_line(make_line(25, 30, 30, 10, 8'h3c, 8'h4b, 8'h5a));
        send_line(make_line(10, 15, 30, 10, 8'h69, 8'h78, 8'h87));
        // single steps and an error term hitting zero
        send_line(make_line(0, 0, 1, 0, 8'h96, 8'ha5, 8'hb4));
        send_line(make_line(5, 5, 4, 6, 8'hc3, 8'hd2, 8'he1));
        send_line(make_line(0, 0, 2, 1, 8'hf0, 8'h0f, 8'hf0));
        send_line(make_line(40, 5, 5, 63, 8'h80, 8'h01, 8'h40));
        stop_sending();
        wait_drained();

        // random lines with gaps on both sides
        push_gap_pct  = 30;
        pop_stall_pct = 25;
        for (int n = 0; n < 50; n++) begin
            send_line(random_line());
            if (n == 30) begin
                stop_sending();
                wait_drained();
            end
        end
        stop_sending();
        wait_drained();

        // random lines at full rate, later with rare stalls on the pixel side
        push_gap_pct  = 0;
        pop_stall_pct = 0;
        for (int n = 0; n < 30; n++) begin
            if (n == 20) begin
                pop_stall_pct = 5;
            end
            send_line(random_line());
        end
        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_pixels == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bls_pkg.sv
hw/rtl/bls_front.sv
hw/rtl/bls_queue.sv
hw/rtl/bls_back.sv
hw/rtl/bresenham_line_stepper_core.sv
hw/rtl/bls_checker.sv
tb/line_pixel_checker.sv
tb/tb.sv
